>>> rtl/rscc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rscc_pkg
// Shared constants for the segment clipper.
// ----------------------------------------------------------------------------
package rscc_pkg;
    localparam int unsigned PLANE_W = 128;
    localparam int unsigned WIDE_W  = 68;   // exact dot sums fit here
    localparam int unsigned T_W     = 19;   // signed Q.16 t with range [-2,2]
    localparam logic signed [T_W-1:0] T_ONE = 19'sd65536;
    localparam logic signed [T_W-1:0] T_SAT = 19'sd131072;
    localparam logic [0:0] CFG_NUM_FACES = 1'b0;
    localparam logic [0:0] CFG_EPSILON   = 1'b1;
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;
endpackage
`default_nettype wire

>>> rtl/ray_segment_convex_clip.sv
`default_nettype none
// Loads write the plane table; a query visits the faces one after another, and each
// usable plane goes through the one-bit-a-cycle divider (a near-parallel face skips it).
// Throughput: one item at a time; results wait in an output register.
// Reset: synchronous active-low; registers reset to num_faces=0, epsilon=4295.
// The plane table is not cleared and is undefined until loaded.
// ----------------------------------------------------------------------------
// ray_segment_convex_clip
// Clips a segment against a plane table held in a synchronous memory.
// ----------------------------------------------------------------------------
module ray_segment_convex_clip #(
    parameter int unsigned MAX_FACES = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_op,
    input  wire logic [5:0]          s_plane_index,
    input  wire logic signed [31:0]  s_normal_x,
    input  wire logic signed [31:0]  s_normal_y,
    input  wire logic signed [31:0]  s_normal_z,
    input  wire logic signed [31:0]  s_plane_offset,
    input  wire logic signed [31:0]  s_origin_x,
    input  wire logic signed [31:0]  s_origin_y,
    input  wire logic signed [31:0]  s_origin_z,
    input  wire logic signed [31:0]  s_dir_x,
    input  wire logic signed [31:0]  s_dir_y,
    input  wire logic signed [31:0]  s_dir_z,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [31:0]         cfg_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_hit,
    output logic [16:0]              m_hit_t
);
    localparam int unsigned AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int unsigned CW = $clog2(MAX_FACES + 1);
    localparam int unsigned W  = rscc_pkg::WIDE_W;
    localparam int unsigned TW = rscc_pkg::T_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MUL, ST_SUM, ST_DIV, ST_WAIT, ST_DONE
    } state_t;

    logic [rscc_pkg::PLANE_W-1:0] mem [MAX_FACES];
    logic [rscc_pkg::PLANE_W-1:0] rd_reg;

    state_t state_reg;
    logic [6:0]  num_faces_reg;
    logic [31:0] eps_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg, dx_reg, dy_reg, dz_reg;
    logic [CW-1:0] cnt_reg, n_reg;
    logic signed [63:0] po_x_reg, po_y_reg, po_z_reg, pd_x_reg, pd_y_reg, pd_z_reg;
    logic signed [63:0] off_reg;
    logic signed [W-1:0] dist_reg, proj_reg;
    logic signed [TW-1:0] entry_reg, exit_reg;
    logic [1:0] seen_reg;
    logic neg_t_reg, entering_reg;
    logic out_valid_reg, out_hit_reg;
    logic [16:0] out_t_reg;
    logic div_start;
    logic div_done;
    logic [TW-1:0] div_q;
    logic [W-1:0] dmag, pmag;
    logic usable, outside;
    logic signed [TW-1:0] t_s;
    logic [CW-1:0] nf_sat;

    assign s_ready   = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_hit     = out_hit_reg;
    assign m_hit_t   = out_t_reg;

    assign nf_sat = (32'(num_faces_reg) > MAX_FACES) ? CW'(MAX_FACES) : CW'(num_faces_reg);

    // plane memory: write on load, registered read during query
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && s_op == rscc_pkg::OP_LOAD &&
            {26'b0, s_plane_index} < 32'(MAX_FACES))
            mem[AW'(s_plane_index)] <= {s_normal_x, s_normal_y, s_normal_z,
                                        s_plane_offset};
        rd_reg <= mem[cnt_reg[AW-1:0]];
    end

    // classify the summed plane
    assign dmag    = dist_reg[W-1] ? W'(-dist_reg) : W'(dist_reg);
    assign pmag    = proj_reg[W-1] ? W'(-proj_reg) : W'(proj_reg);
    assign usable  = (pmag != '0) && (pmag >= {{(W-32){1'b0}}, eps_reg});
    assign outside = !dist_reg[W-1] && (dist_reg != '0);
    assign div_start = (state_reg == ST_DIV) && usable;
    assign t_s = neg_t_reg ? -$signed(div_q) : $signed(div_q);

    rscc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(dmag), .den(pmag), .done(div_done), .quot(div_q)
    );

    // sequencer: read, multiply, sum, divide if usable, update bounds per plane
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            num_faces_reg <= 7'd0;
            eps_reg       <= 32'd4295;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    rscc_pkg::CFG_NUM_FACES: num_faces_reg <= cfg_data[6:0];
                    rscc_pkg::CFG_EPSILON:   eps_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready && s_op == rscc_pkg::OP_QUERY) begin
                        ox_reg <= s_origin_x; oy_reg <= s_origin_y;
                        oz_reg <= s_origin_z; dx_reg <= s_dir_x;
                        dy_reg <= s_dir_y; dz_reg <= s_dir_z;
                        cnt_reg   <= '0;
                        n_reg     <= nf_sat;
                        entry_reg <= '0;
                        exit_reg  <= rscc_pkg::T_ONE;
                        seen_reg  <= 2'b00;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= (cnt_reg == n_reg) ? ST_DONE : ST_MUL;
                end
                ST_MUL: begin
                    po_x_reg <= ox_reg * $signed(rd_reg[127:96]);
                    po_y_reg <= oy_reg * $signed(rd_reg[95:64]);
                    po_z_reg <= oz_reg * $signed(rd_reg[63:32]);
                    pd_x_reg <= dx_reg * $signed(rd_reg[127:96]);
                    pd_y_reg <= dy_reg * $signed(rd_reg[95:64]);
                    pd_z_reg <= dz_reg * $signed(rd_reg[63:32]);
                    off_reg  <= {{16{rd_reg[31]}}, rd_reg[31:0], 16'b0};
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    dist_reg <= W'(po_x_reg) + W'(po_y_reg) + W'(po_z_reg) + W'(off_reg);
                    proj_reg <= W'(pd_x_reg) + W'(pd_y_reg) + W'(pd_z_reg);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    neg_t_reg    <= (dist_reg != '0) && (dist_reg[W-1] == proj_reg[W-1]);
                    entering_reg <= proj_reg[W-1];
                    if (usable) begin
                        state_reg <= ST_WAIT;
                    end else if (outside) begin
                        out_hit_reg   <= 1'b0;
                        out_t_reg     <= '0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end else begin
                        cnt_reg   <= cnt_reg + CW'(1);
                        state_reg <= ST_READ;
                    end
                end
                ST_WAIT: begin
                    if (div_done) begin
                        if (entering_reg) begin
                            if (t_s > entry_reg) entry_reg <= t_s;
                            seen_reg[0] <= 1'b1;
                        end else begin
                            if (t_s < exit_reg) exit_reg <= t_s;
                            seen_reg[1] <= 1'b1;
                        end
                        cnt_reg   <= cnt_reg + CW'(1);
                        state_reg <= ST_READ;
                    end
                end
                ST_DONE: begin
                    out_hit_reg <= (seen_reg == 2'b11) && (entry_reg <= exit_reg) &&
                                   !exit_reg[TW-1];
                    out_t_reg   <= ((seen_reg == 2'b11) && (entry_reg <= exit_reg) &&
                                   !exit_reg[TW-1]) ? entry_reg[16:0] : 17'd0;
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/rscc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rscc_div
// Restoring divider: floor(num*2^16/den), saturated to 2.0, one bit a cycle.
// ----------------------------------------------------------------------------
module rscc_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [rscc_pkg::WIDE_W-1:0]   num,
    input  wire logic [rscc_pkg::WIDE_W-1:0]   den,
    output logic                               done,
    output logic [rscc_pkg::T_W-1:0]           quot
);
    localparam int unsigned RW = rscc_pkg::WIDE_W + 19;
    logic [RW-1:0] rem_reg, den_reg;
    logic [rscc_pkg::T_W-1:0] q_reg;
    logic [4:0] bit_reg;
    logic busy_reg, done_reg, sat_reg;
    logic [RW-1:0] dsh;

    assign dsh = den_reg << bit_reg;

    // iterate quotient bits 17 down to 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= {3'b0, num, 16'b0};
                den_reg  <= {19'b0, den};
                q_reg    <= '0;
                bit_reg  <= 5'd17;
                busy_reg <= 1'b1;
                sat_reg  <= ({3'b0, num, 16'b0} >= ({19'b0, den} << 18));
            end else if (busy_reg) begin
                if (!sat_reg && rem_reg >= dsh) begin
                    rem_reg <= rem_reg - dsh;
                    q_reg[bit_reg] <= 1'b1;
                end
                if (bit_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    bit_reg <= bit_reg - 5'd1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = (sat_reg || q_reg > rscc_pkg::T_SAT) ? rscc_pkg::T_SAT : q_reg;
endmodule
`default_nettype wire
